[rtl/core/assert_macros.svh]
// Assertion macros used by the scan controller of the k-th occurrence lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[rtl/core/kol_pkg.sv]
// Package: widths, action codes and shared types of the k-th occurrence lookup.
`default_nettype none
package kol_pkg;

  localparam int KOL_ACT_W     = 2;
  localparam int KOL_VAL_W     = 32;
  localparam int KOL_OCC_W     = 11;
  localparam int KOL_POS_W     = 11;
  localparam int KOL_MAX_ITEMS = 1024;

  localparam logic [KOL_ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [KOL_ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [KOL_ACT_W-1:0] ACT_QUERY  = 2'd2;

  // Finished query answer offered by the scan controller
  typedef struct packed {
    logic                 valid;
    logic [KOL_POS_W-1:0] position;
    logic                 found;
  } kol_res_t;

endpackage
`default_nettype wire

[rtl/core/kol_if.sv]
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface kol_req_if;
  import kol_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [KOL_ACT_W-1:0]        action;
  logic signed [KOL_VAL_W-1:0] value;
  logic [KOL_OCC_W-1:0]        occurrence;

  modport source (output valid, action, value, occurrence, input ready);
  modport sink   (input valid, action, value, occurrence, output ready);
endinterface

interface kol_res_if;
  import kol_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KOL_POS_W-1:0] position;
  logic                 found;

  modport source (output valid, position, found, input ready);
  modport sink   (input valid, position, found, output ready);
endinterface
`default_nettype wire

[rtl/core/kol_store.sv]
// Element store: single-port-write, registered-read synchronous memory.
`default_nettype none
module kol_store
  import kol_pkg::*;
#(
  parameter int MAX_ITEMS = KOL_MAX_ITEMS
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
  input  wire logic [KOL_VAL_W-1:0]         wr_data,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_ITEMS)-1:0] rd_addr,
  output logic      [KOL_VAL_W-1:0]         rd_data
);

  logic [KOL_VAL_W-1:0] mem [0:MAX_ITEMS-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/kol_scan.sv]
// Scan controller: element count, appends and the sequential query scan.
`default_nettype none
`include "assert_macros.svh"
module kol_scan
  import kol_pkg::*;
#(
  parameter int MAX_ITEMS = KOL_MAX_ITEMS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  kol_req_if.sink                           in_chan,
  output kol_res_t                          res,
  input  wire logic                         res_take,
  output logic                              wr_en,
  output logic [$clog2(MAX_ITEMS)-1:0]      wr_addr,
  output logic [KOL_VAL_W-1:0]              wr_data,
  output logic                              rd_en,
  output logic [$clog2(MAX_ITEMS)-1:0]      rd_addr,
  input  wire logic [KOL_VAL_W-1:0]         rd_data
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = (CW > KOL_OCC_W) ? CW : KOL_OCC_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        addr_r, addr_nxt;
  logic                 rd_vld_r;
  logic [AW-1:0]        rd_idx_r;
  logic [SW-1:0]        seen_r, seen_nxt;
  logic [SW-1:0]        seen_inc;
  logic [KOL_VAL_W-1:0] value_r, value_nxt;
  logic [KOL_OCC_W-1:0] occ_r, occ_nxt;
  logic [KOL_POS_W-1:0] pos_r, pos_nxt;
  logic                 found_r, found_nxt;
  logic                 accept;
  logic                 match;
  logic                 hit;
  logic [CW-1:0]        pos_full;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // append writes the next free slot
  assign wr_en   = accept && (in_chan.action == ACT_APPEND) && (count_r != CW'(MAX_ITEMS));
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = $unsigned(in_chan.value);

  // one read per cycle while unread elements remain
  assign rd_en   = (state_r == ST_SCAN) && (addr_r < count_r);
  assign rd_addr = addr_r[AW-1:0];

  // compare stage on the returned element
  assign match    = rd_vld_r && (rd_data == value_r);
  assign seen_inc = seen_r + 1'b1;
  assign hit      = match && (seen_inc == SW'(occ_r));
  assign pos_full = CW'(rd_idx_r) + 1'b1;

  assign res.valid    = (state_r == ST_DONE);
  assign res.position = pos_r;
  assign res.found    = found_r;

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    seen_nxt  = seen_r;
    value_nxt = value_r;
    occ_nxt   = occ_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_chan.action)
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_QUERY: begin
              value_nxt = $unsigned(in_chan.value);
              occ_nxt   = in_chan.occurrence;
              addr_nxt  = '0;
              seen_nxt  = '0;
              pos_nxt   = '0;
              found_nxt = 1'b0;
              // zero occurrence answers at once
              state_nxt = (in_chan.occurrence == '0) ? ST_DONE : ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (match) begin
          seen_nxt = seen_inc;
        end
        if (hit) begin
          pos_nxt   = KOL_POS_W'(pos_full);
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (!rd_vld_r && !rd_en) begin
          // every stored element compared, too few occurrences
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_en;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    rd_idx_r <= addr_r[AW-1:0];
    seen_r   <= seen_nxt;
    value_r  <= value_nxt;
    occ_r    <= occ_nxt;
    pos_r    <= pos_nxt;
    found_r  <= found_nxt;
  end

  `ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CW'(MAX_ITEMS), "count above capacity")
  `ASSERT_CLK(a_count_held, clk, rst_n, (state_r != ST_IDLE) |=> $stable(count_r), "count moved during query")
  `ASSERT_CLK(a_seen_below_k, clk, rst_n, (state_r == ST_SCAN) |-> (seen_r < SW'(occ_r)), "seen reached k in scan")
  `ASSERT_CLK(a_hit_reported, clk, rst_n, (state_r == ST_SCAN && hit) |=> (res.valid && res.found), "hit not reported")

endmodule
`default_nettype wire

[rtl/core/kth_occurrence_lookup.sv]
// Top level of the k-th occurrence lookup: store, scan controller, result register.
`default_nettype none
// Holds up to MAX_ITEMS signed 32-bit elements in a single on-chip memory.
// Clear and append requests are applied when accepted; an append to a full
// store is dropped. A query for the k-th element equal to a value walks the
// stored elements in order, one memory read per cycle, and stops at the
// k-th match or after the last stored element; a query with k zero is
// answered without a scan. One query is in progress at a time and no
// request is accepted until its answer is handed to the result register,
// which holds it until the consumer takes it; the next request is accepted
// in the cycle after that at the earliest. The answer gives the 1-based
// position (low 11 bits) and a found flag, or position 0 and found 0 when
// there are fewer than k occurrences. No clearing pass is needed after reset.
module kth_occurrence_lookup
  import kol_pkg::*;
#(
  parameter int MAX_ITEMS = KOL_MAX_ITEMS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kol_req_if.sink    in_chan,
  kol_res_if.source  out_chan
);

  localparam int AW = $clog2(MAX_ITEMS);

  kol_res_t             res;
  logic                 res_take;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KOL_VAL_W-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [KOL_VAL_W-1:0] rd_data;

  logic                 out_valid_r, out_valid_nxt;
  logic [KOL_POS_W-1:0] out_pos_r;
  logic                 out_found_r;

  kol_store #(.MAX_ITEMS(MAX_ITEMS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kol_scan #(.MAX_ITEMS(MAX_ITEMS)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .res      (res),
    .res_take (res_take),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // result register takes a new answer when empty or being drained
  assign res_take = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      out_pos_r   <= res.position;
      out_found_r <= res.found;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.position = out_pos_r;
  assign out_chan.found    = out_found_r;

endmodule
`default_nettype wire
